/* sv/bfbs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bloom filter bit store package
// Shared sizes, operation codes and the filter size clamp.
// ----------------------------------------------------------------------------
package bfbs_pkg;

    localparam int MAX_WORDS   = 1024;
    localparam int WORD_BITS   = 64;
    localparam int MAX_BITS    = MAX_WORDS * WORD_BITS;
    localparam int WIDX_W      = $clog2(MAX_WORDS);
    localparam int BPOS_W      = $clog2(WORD_BITS);
    localparam int REM_W       = WIDX_W + BPOS_W;
    localparam int FB_W        = 17;
    localparam int HASH_W      = 32;
    localparam int STEP_W      = $clog2(HASH_W);
    localparam logic [FB_W-1:0] FB_RESET = FB_W'(65536);

    typedef enum logic [1:0] {
        FN_ADD   = 2'd0,
        FN_QUERY = 2'd1,
        FN_MERGE = 2'd2,
        FN_READ  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_WR
    } t_state;

    // Size zero counts as one bit; sizes above the array clamp to its size.
    function automatic logic [FB_W-1:0] eff_bits(input logic [FB_W-1:0] v);
        logic [FB_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = FB_W'(1);
        end else if (v > FB_W'(MAX_BITS)) begin
            r = FB_W'(MAX_BITS);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/bloom_filter_bit_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bloom filter bit store
// 1024 x 64-bit bit array with hash add/query runs and word merge/read.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    func, hash_value, last_hash,
//                                                  word_index, word_data
//  out       output     o_out_valid / i_out_stall  answer, read_data
//  cfg       input      i_cfg_valid / o_cfg_ready  filter_bits
//
// An add or query hash runs the bit-serial remainder by the filter size (32 steps
// and a done strobe), then one memory read and one write-back state; the next
// transaction is accepted only after the write-back.
// A merge or read skips the remainder: registered memory read, then write-back.
// After reset a clearing pass zeros all 1024 words of the array, one word per
// cycle; input stays stalled meanwhile, configuration writes are taken.
// A held result in the output register blocks only the next result-producing
// write-back, not acceptance of the next transaction.
// ----------------------------------------------------------------------------
module bloom_filter_bit_store
    import bfbs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_func,
    input  wire logic [HASH_W-1:0]    i_hash_value,
    input  wire logic                 i_last_hash,
    input  wire logic [WIDX_W-1:0]    i_word_index,
    input  wire logic [WORD_BITS-1:0] i_word_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_answer,
    output logic [WORD_BITS-1:0]      o_read_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [FB_W-1:0]      i_cfg_filter_bits
);

    t_state r_state;
    t_state n_state;

    logic [FB_W-1:0]      r_filter_bits;
    logic                 r_run_flag;
    logic [WIDX_W-1:0]    r_clr_idx;
    t_func                r_func;
    logic                 r_last;
    logic [WIDX_W-1:0]    r_addr;
    logic [BPOS_W-1:0]    r_bitpos;
    logic [WORD_BITS-1:0] r_wdata;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_out_valid;
    logic                 r_answer;
    logic [WORD_BITS-1:0] r_read_data;
    logic [WORD_BITS-1:0] r_mem [0:MAX_WORDS-1];

    logic                 w_accept;
    logic                 w_div_done;
    logic [REM_W-1:0]     w_rem;
    logic                 w_is_hash;
    logic                 w_need_out;
    logic                 w_can_commit;
    logic                 w_bit_set;
    logic                 w_flag_after;
    logic [WORD_BITS-1:0] w_mask;
    logic                 w_mem_we;
    logic [WIDX_W-1:0]    w_mem_waddr;
    logic [WORD_BITS-1:0] w_mem_wdata;
    logic                 w_commit;
    logic                 w_out_load;
    logic                 w_answer;
    logic [WORD_BITS-1:0] w_read_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && (r_state == ST_IDLE);

    bfbs_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && (i_func == FN_ADD || i_func == FN_QUERY)),
        .i_dividend (i_hash_value),
        .i_divisor  (eff_bits(r_filter_bits)),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    assign w_is_hash    = (r_func == FN_ADD) || (r_func == FN_QUERY);
    assign w_need_out   = !w_is_hash || r_last;
    assign w_can_commit = !w_need_out || !r_out_valid || !i_out_stall;
    assign w_mask       = WORD_BITS'(1) << r_bitpos;
    assign w_bit_set    = r_rdata[r_bitpos];
    assign w_flag_after = r_run_flag && w_bit_set;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == WIDX_W'(MAX_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_func == FN_ADD || i_func == FN_QUERY) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_WR;
            end
            ST_WR: begin
                if (w_can_commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Memory write, result and write-back outputs.
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_addr;
        w_mem_wdata = r_rdata;
        w_commit    = 1'b0;
        w_answer    = 1'b0;
        w_read_data = '0;
        case (r_state)
            ST_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_idx;
                w_mem_wdata = '0;
            end
            ST_WR: begin
                w_commit = w_can_commit;
                case (r_func)
                    FN_ADD: begin
                        w_mem_we    = w_can_commit;
                        w_mem_wdata = r_rdata | w_mask;
                        w_answer    = w_flag_after;
                    end
                    FN_QUERY: begin
                        w_answer = w_flag_after;
                    end
                    FN_MERGE: begin
                        w_mem_we    = w_can_commit;
                        w_mem_wdata = r_rdata | r_wdata;
                        w_read_data = r_rdata | r_wdata;
                    end
                    FN_READ: begin
                        w_read_data = r_rdata;
                    end
                    default: begin
                        w_read_data = r_rdata;
                    end
                endcase
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    assign w_out_load = w_commit && w_need_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_idx     <= '0;
            r_filter_bits <= FB_RESET;
            r_run_flag    <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + WIDX_W'(1);
            end
            if (i_cfg_valid) begin
                r_filter_bits <= i_cfg_filter_bits;
            end
            if (w_commit && w_is_hash) begin
                r_run_flag <= r_last ? 1'b1 : w_flag_after;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= t_func'(i_func);
            r_last  <= i_last_hash;
            r_addr  <= i_word_index;
            r_wdata <= i_word_data;
        end else if (r_state == ST_DIV && w_div_done) begin
            r_addr   <= w_rem[REM_W-1:BPOS_W];
            r_bitpos <= w_rem[BPOS_W-1:0];
        end
        if (w_out_load) begin
            r_answer    <= w_answer;
            r_read_data <= w_read_data;
        end
    end

    // Bit array: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (r_state == ST_RD) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_answer    = r_answer;
    assign o_read_data = r_read_data;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_DIV || r_state == ST_RD))
        else $error("accepted transaction did not start work");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("reduction finished outside the wait state");

    a_write_when_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_state == ST_CLEAR || r_state == ST_WR))
        else $error("array written outside clear or write-back");

    a_flag_rearmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && w_is_hash && r_last) |=> r_run_flag)
        else $error("run flag not rearmed after end of run");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_out_load)
        else $error("held result overwritten");

endmodule
`default_nettype wire

/* sv/bfbs_mod.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bloom filter hash reduction unit
// Restoring remainder of a 32-bit hash by the filter size, one bit per cycle.
// ----------------------------------------------------------------------------
module bfbs_mod
    import bfbs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [HASH_W-1:0] i_dividend,
    input  wire logic [FB_W-1:0]   i_divisor,
    output logic                   o_done,
    output logic [REM_W-1:0]       o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [HASH_W-1:0] r_quo;
    logic [REM_W-1:0]  r_rem;
    logic [FB_W-1:0]   r_div;
    logic [FB_W-1:0]   w_trial;
    logic [FB_W-1:0]   w_diff;

    // The partial remainder stays below the divisor, so it fits REM_W bits.
    assign w_trial = {r_rem, r_quo[HASH_W-1]};
    assign w_diff  = w_trial - r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(HASH_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[HASH_W-2:0], 1'b0};
            if (w_trial >= r_div) begin
                r_rem <= w_diff[REM_W-1:0];
            end else begin
                r_rem <= w_trial[REM_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("reduction started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a running reduction");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ({1'b0, r_rem} < r_div))
        else $error("remainder not below divisor");

endmodule
`default_nettype wire

/* tb/bloom_filter_bit_store_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter bit store checker
// Watches the request, reply and size channels and keeps a shadow copy of the
// bit array. Each reply is compared with the oldest predicted reply, and the
// error count and the number of replies still owed are handed to the top.
// ----------------------------------------------------------------------------
module bloom_filter_bit_store_checker
    import bfbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [1:0]           i_func,
    input  logic [HASH_W-1:0]    i_hash_value,
    input  logic                 i_last_hash,
    input  logic [WIDX_W-1:0]    i_word_index,
    input  logic [WORD_BITS-1:0] i_word_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_answer,
    input  logic [WORD_BITS-1:0] i_read_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [FB_W-1:0]      i_cfg_filter_bits,
    output int                   o_err_count,
    output int                   o_pending
);

    typedef struct packed {
        logic                 answer;
        logic [WORD_BITS-1:0] word;
    } t_filter_reply;

    t_filter_reply        expected_replies[$];
    t_filter_reply        oldest_reply;
    logic [WORD_BITS-1:0] shadow_words [MAX_WORDS];
    logic                 all_hit;
    logic [FB_W-1:0]      span_bits;
    logic [HASH_W-1:0]    bit_no;
    logic [WIDX_W-1:0]    word_no;
    logic [WORD_BITS-1:0] bit_mask;
    int                   err_count;

    initial begin
        o_err_count = 0;
        o_pending   = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_replies.delete();
            for (int k = 0; k < MAX_WORDS; k++) begin
                shadow_words[k] = '0;
            end
            all_hit   = 1'b1;
            span_bits = FB_RESET;
            err_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected reply, expected none, got answer %0b data %h",
                             $time, i_answer, i_read_data);
                    err_count++;
                end else begin
                    oldest_reply = expected_replies.pop_front();
                    if (i_answer !== oldest_reply.answer) begin
                        $display("%0t: answer mismatch, expected %0b, got %0b",
                                 $time, oldest_reply.answer, i_answer);
                        err_count++;
                    end
                    if (i_read_data !== oldest_reply.word) begin
                        $display("%0t: read_data mismatch, expected %h, got %h",
                                 $time, oldest_reply.word, i_read_data);
                        err_count++;
                    end
                end
            end

            // A size of zero acts as one bit, and anything above the array is clipped.
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_filter_bits == '0) begin
                    span_bits = FB_W'(1);
                end else if (i_cfg_filter_bits > FB_W'(MAX_BITS)) begin
                    span_bits = FB_W'(MAX_BITS);
                end else begin
                    span_bits = i_cfg_filter_bits;
                end
            end

            if (i_in_valid && !i_in_stall) begin
                case (i_func)
                    FN_ADD, FN_QUERY: begin
                        bit_no   = i_hash_value % {{(HASH_W - FB_W){1'b0}}, span_bits};
                        word_no  = bit_no[REM_W-1:BPOS_W];
                        bit_mask = WORD_BITS'(1) << bit_no[BPOS_W-1:0];
                        // Adds and queries share one flag, so a mixed run ANDs both tests.
                        if ((shadow_words[word_no] & bit_mask) == '0) begin
                            all_hit = 1'b0;
                        end
                        if (i_func == FN_ADD) begin
                            shadow_words[word_no] = shadow_words[word_no] | bit_mask;
                        end
                        if (i_last_hash) begin
                            expected_replies.push_back('{answer: all_hit, word: '0});
                            all_hit = 1'b1;
                        end
                    end
                    default: begin
                        if (i_func == FN_MERGE) begin
                            shadow_words[i_word_index] = shadow_words[i_word_index]
                                                         | i_word_data;
                        end
                        expected_replies.push_back('{answer: 1'b0,
                                                     word: shadow_words[i_word_index]});
                    end
                endcase
            end
        end
        o_err_count <= err_count;
        o_pending   <= expected_replies.size();
    end

endmodule

/* tb/bloom_filter_bit_store_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter bit store testbench
// Drives hash runs, word merges and reads through a series of filter sizes,
// with random gaps on the request side and random stalls on the reply side.
// The checker beside the block predicts every reply; this top gives the verdict.
// ----------------------------------------------------------------------------
module bloom_filter_bit_store_test;
    import bfbs_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 48;
    localparam int ITEMS_PER_PHASE = 125;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           in_func;
    logic [HASH_W-1:0]    in_hash;
    logic                 in_last;
    logic [WIDX_W-1:0]    in_widx;
    logic [WORD_BITS-1:0] in_wdata;
    logic                 out_valid;
    logic                 out_stall;
    logic                 out_answer;
    logic [WORD_BITS-1:0] out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [FB_W-1:0]      cfg_bits;

    int                   err_count;
    int                   pending;
    int                   cycle_count;
    int                   phase_items;
    int                   stall_left;
    bit                   idle_on;
    bit                   run_open;
    logic [HASH_W-1:0]    added_hashes[$];
    int unsigned          size_plan[$];

    bloom_filter_bit_store u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_func            (in_func),
        .i_hash_value      (in_hash),
        .i_last_hash       (in_last),
        .i_word_index      (in_widx),
        .i_word_data       (in_wdata),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_answer          (out_answer),
        .o_read_data       (out_data),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_filter_bits (cfg_bits)
    );

    bloom_filter_bit_store_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_func            (in_func),
        .i_hash_value      (in_hash),
        .i_last_hash       (in_last),
        .i_word_index      (in_widx),
        .i_word_data       (in_wdata),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_answer          (out_answer),
        .i_read_data       (out_data),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_filter_bits (cfg_bits),
        .o_err_count       (err_count),
        .o_pending         (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("bloom_filter_bit_store_test: done, errors");
        $finish;
    end

    // Reply-side stalls come in bursts of random length.
    always @(negedge clk) begin
        if (!idle_on) begin
            stall_left = 0;
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    function automatic logic [WORD_BITS-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Replaying earlier adds lets queries and repeated adds find their bits set.
    function automatic logic [HASH_W-1:0] pick_hash();
        int choice;
        choice = $urandom_range(0, 9);
        if (choice < 4 && added_hashes.size() > 0) begin
            return added_hashes[$urandom_range(0, added_hashes.size() - 1)];
        end else if (choice == 4) begin
            return HASH_W'($urandom_range(0, 200));
        end else if (choice == 5) begin
            return '1 - HASH_W'($urandom_range(0, 3));
        end
        return $urandom;
    endfunction

    task automatic send_item(input t_func f, input logic [HASH_W-1:0] h, input logic lst,
                             input logic [WIDX_W-1:0] widx,
                             input logic [WORD_BITS-1:0] wdata);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
        end
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_func  <= f;
        in_hash  <= h;
        in_last  <= lst;
        in_widx  <= widx;
        in_wdata <= wdata;
        do begin
            @(posedge clk);
        end while (in_stall);
        if (f == FN_ADD || f == FN_QUERY) begin
            run_open = !lst;
        end
        if (f == FN_ADD) begin
            added_hashes.push_back(h);
            if (added_hashes.size() > 64) begin
                void'(added_hashes.pop_front());
            end
        end
        phase_items++;
    endtask

    // Closes any open run, then waits until every reply is in and the block is quiet.
    task automatic finish_phase();
        if (run_open) begin
            send_item(FN_QUERY, pick_hash(), 1'b1,
                      WIDX_W'($urandom_range(0, MAX_WORDS - 1)), rand_word());
        end
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_size(input logic [FB_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_bits  <= value;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        send_item(FN_ADD,   32'd0,          1'b1, 10'd7,    rand_word());
        send_item(FN_ADD,   32'd0,          1'b1, 10'd9,    rand_word());
        send_item(FN_QUERY, 32'd0,          1'b1, 10'd0,    '1);
        send_item(FN_QUERY, 32'hFFFF_FFFF,  1'b1, 10'd1023, '0);
        send_item(FN_ADD,   32'hFFFF_FFFF,  1'b1, 10'd1,    rand_word());
        send_item(FN_QUERY, 32'hFFFF_FFFF,  1'b1, 10'd2,    rand_word());
        // A multi-hash add run where only some bits are new.
        send_item(FN_ADD,   32'd5,          1'b0, 10'd3,    rand_word());
        send_item(FN_ADD,   32'd77,         1'b0, 10'd4,    rand_word());
        send_item(FN_ADD,   32'd0,          1'b1, 10'd5,    rand_word());
        // Mixed runs: one that stays clean, one where the add flips a bit.
        send_item(FN_QUERY, 32'd0,          1'b0, 10'd6,    rand_word());
        send_item(FN_ADD,   32'd0,          1'b1, 10'd8,    rand_word());
        send_item(FN_ADD,   32'd1000,       1'b0, 10'd10,   rand_word());
        send_item(FN_QUERY, 32'd5,          1'b1, 10'd11,   rand_word());
        send_item(FN_MERGE, $urandom,       1'b0, 10'd0,    '1);
        send_item(FN_READ,  $urandom,       1'b1, 10'd0,    rand_word());
        send_item(FN_MERGE, $urandom,       1'b1, 10'd1023, {16{4'hA}});
        send_item(FN_READ,  $urandom,       1'b0, 10'd1023, '0);
        send_item(FN_QUERY, 32'd63,         1'b1, 10'd12,   rand_word());
        send_item(FN_QUERY, 32'd65535,      1'b1, 10'd13,   rand_word());
        send_item(FN_MERGE, $urandom,       1'b0, 10'd3,    64'd1 << 63);
        send_item(FN_MERGE, $urandom,       1'b0, 10'd512,  '0);
        // A word operation in the middle of a run must not disturb the run.
        send_item(FN_ADD,   32'd2000,       1'b0, 10'd14,   rand_word());
        send_item(FN_READ,  $urandom,       1'b0, 10'd5,    rand_word());
        send_item(FN_ADD,   32'd2001,       1'b1, 10'd15,   rand_word());
        send_item(FN_QUERY, 32'd65534,      1'b1, 10'd16,   rand_word());
    endtask

    task automatic run_random(input int target);
        int                   choice;
        int                   len;
        bit                   mixed;
        t_func                run_func;
        t_func                f;
        logic [WIDX_W-1:0]    widx;
        logic [WORD_BITS-1:0] wdata;
        phase_items = 0;
        while (phase_items < target) begin
            choice = $urandom_range(0, 99);
            if (choice < 60) begin
                len      = $urandom_range(1, 6);
                mixed    = ($urandom_range(0, 99) < 15);
                run_func = $urandom_range(0, 1) ? FN_QUERY : FN_ADD;
                for (int n = 0; n < len; n++) begin
                    f = run_func;
                    if (mixed) begin
                        f = $urandom_range(0, 1) ? FN_QUERY : FN_ADD;
                    end
                    send_item(f, pick_hash(), n == len - 1,
                              WIDX_W'($urandom_range(0, MAX_WORDS - 1)), rand_word());
                end
            end else if (choice < 85) begin
                f = $urandom_range(0, 1) ? FN_MERGE : FN_READ;
                case ($urandom_range(0, 3))
                    0: widx = WIDX_W'($urandom_range(0, 3));
                    1: widx = WIDX_W'(MAX_WORDS - 1);
                    default: widx = WIDX_W'($urandom_range(0, MAX_WORDS - 1));
                endcase
                case ($urandom_range(0, 3))
                    0: wdata = '1;
                    1: wdata = WORD_BITS'(1) << $urandom_range(0, WORD_BITS - 1);
                    2: wdata = '0;
                    default: wdata = rand_word();
                endcase
                send_item(f, $urandom, 1'($urandom_range(0, 1)), widx, wdata);
            end else begin
                send_item(t_func'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
                          WIDX_W'($urandom_range(0, MAX_WORDS - 1)), rand_word());
            end
        end
    endtask

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_func    = FN_ADD;
        in_hash    = '0;
        in_last    = 1'b0;
        in_widx    = '0;
        in_wdata   = '0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_bits   = '0;
        stall_left = 0;
        idle_on    = 1'b1;
        run_open   = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        finish_phase();

        // Sizes cover one bit, zero, word edges, above the array and full size.
        size_plan = {1, 0, 64, 100, 131071, 65537, 4096, 65535,
                     $urandom_range(2, 3000), 65536};
        for (int p = 0; p < size_plan.size(); p++) begin
            write_size(FB_W'(size_plan[p]));
            if (p == size_plan.size() - 1) begin
                idle_on = 1'b0;
            end
            run_random(ITEMS_PER_PHASE);
            finish_phase();
        end

        if (err_count == 0 && pending == 0) begin
            $display("bloom_filter_bit_store_test: done, clean");
        end else begin
            $display("bloom_filter_bit_store_test: done, errors");
        end
        $finish;
    end

endmodule
